### rtl/rsnh_pkg.sv
package rsnh_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_SEG_DEF  = 128;
  localparam int FRAC_BITS_DEF = 4;

  // Field widths.
  localparam int CRD_W  = 13;
  localparam int IDX_W  = 7;
  localparam int HIT_W  = 17;
  localparam int UNIT_W = 16;
  localparam int CFG_W  = 13;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 2'd2;

  localparam logic [CRD_W-1:0] ORIGIN_RST = 13'd512;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Square root unit: radicand is the squared length shifted up by 16.
  localparam int SQ_W     = 44;
  localparam int SQ_RW    = 22;
  localparam int SQ_STEPS = 22;

  // Q1.14 one.
  localparam int UNIT_ONE = 16384;

  typedef struct packed {
    logic signed [CRD_W-1:0]  ax;
    logic signed [CRD_W-1:0]  ay;
    logic signed [CRD_W-1:0]  bx;
    logic signed [CRD_W-1:0]  by;
    logic signed [UNIT_W-1:0] ux;
    logic signed [UNIT_W-1:0] uy;
  } seg_entry_t;

endpackage

### rtl/rsnh_in_if.sv
interface rsnh_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [6:0]         seg_index;
  logic signed [12:0] seg_ax;
  logic signed [12:0] seg_ay;
  logic signed [12:0] seg_bx;
  logic signed [12:0] seg_by;
  logic signed [12:0] target_x;
  logic signed [12:0] target_y;

  modport source (
    output valid, kind, seg_index, seg_ax, seg_ay, seg_bx, seg_by, target_x, target_y,
    input  ready
  );
  modport sink (
    input  valid, kind, seg_index, seg_ax, seg_ay, seg_bx, seg_by, target_x, target_y,
    output ready
  );
endinterface

### rtl/rsnh_out_if.sv
interface rsnh_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [6:0]         hit_index;
  logic signed [16:0] hit_x;
  logic signed [16:0] hit_y;
  logic signed [15:0] reflect_x;
  logic signed [15:0] reflect_y;

  modport source (
    output valid, hit, hit_index, hit_x, hit_y, reflect_x, reflect_y,
    input  ready
  );
  modport sink (
    input  valid, hit, hit_index, hit_x, hit_y, reflect_x, reflect_y,
    output ready
  );
endinterface

### rtl/rsnh_div_cell.sv
module rsnh_div_cell #(
  parameter int DW = 48,
  parameter int QW = 18
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          v_i,
  input  logic          neg_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] dsh_i,
  input  logic [QW-1:0] q_i,
  output logic          v_o,
  output logic          neg_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] dsh_o,
  output logic [QW-1:0] q_o
);

  logic ge;
  assign ge = (rem_i >= dsh_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_o <= 1'b0;
    end else begin
      v_o <= v_i;
    end
  end

  // One quotient bit per cell; the shifted divisor moves down one place.
  always_ff @(posedge clk_i) begin
    neg_o <= neg_i;
    rem_o <= ge ? (rem_i - dsh_i) : rem_i;
    dsh_o <= dsh_i >> 1;
    q_o   <= {q_i[QW-2:0], ge};
  end

endmodule

### rtl/rsnh_divider.sv
module rsnh_divider #(
  parameter int DW = 48,
  parameter int QW = 18
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_v_i,
  input  logic          in_neg_i,
  input  logic [DW-1:0] in_mag_i,
  input  logic [DW-1:0] in_den_i,
  output logic          out_v_o,
  output logic          out_neg_o,
  output logic [QW-1:0] out_q_o
);

  logic          v   [QW+1];
  logic          neg [QW+1];
  logic [DW-1:0] rem [QW+1];
  logic [DW-1:0] dsh [QW+1];
  logic [QW-1:0] q   [QW+1];

  // The quotient is known to fit in QW bits, so the divisor starts QW-1 places up.
  assign v[0]   = in_v_i;
  assign neg[0] = in_neg_i;
  assign rem[0] = in_mag_i;
  assign dsh[0] = in_den_i << (QW - 1);
  assign q[0]   = '0;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    rsnh_div_cell #(.DW(DW), .QW(QW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .v_i    (v[i]),
      .neg_i  (neg[i]),
      .rem_i  (rem[i]),
      .dsh_i  (dsh[i]),
      .q_i    (q[i]),
      .v_o    (v[i+1]),
      .neg_o  (neg[i+1]),
      .rem_o  (rem[i+1]),
      .dsh_o  (dsh[i+1]),
      .q_o    (q[i+1])
    );
  end

  assign out_v_o   = v[QW];
  assign out_neg_o = neg[QW];
  assign out_q_o   = q[QW];

endmodule

### rtl/rsnh_isqrt.sv
module rsnh_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rsnh_pkg::SQ_W-1:0] rad_i,
  output logic                      done_o,
  output logic [rsnh_pkg::SQ_RW-1:0] root_o
);
  import rsnh_pkg::*;

  logic            busy_q;
  logic [4:0]      cnt_q;
  logic [SQ_W-1:0] n_q, r_q, bit_q;
  logic [SQ_W-1:0] trial;

  assign trial  = r_q + bit_q;
  assign root_o = r_q[SQ_RW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(SQ_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // Digit-by-digit root, two radicand bits per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= rad_i;
      r_q   <= '0;
      bit_q <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_q) begin
      if (n_q >= trial) begin
        n_q <= n_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

### rtl/ray_segment_nearest_hit_reflect.sv
// Channel   Dir  Beat carries
// in_i      in   kind, seg_index, segment ends (load) or target point (query)
// out_o     out  hit, hit_index, hit_x, hit_y, reflect_x, reflect_y
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// One item at a time. A load runs a square root, then two divisions issued back
// to back into the divider cell chain (FRAC_BITS+14 cells, at least 15).
// A query scans active segments through a five-stage compare pipeline, then on
// a hit runs divisions, a root and the reflection; a miss skips them.
// Reset clears control and the active count and sets the origin to 512; the
// segment table is not cleared.
// A result waiting in the output register holds the next result back.
module ray_segment_nearest_hit_reflect #(
  parameter int MAX_SEGMENTS = rsnh_pkg::MAX_SEG_DEF,
  parameter int FRAC_BITS    = rsnh_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rsnh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rsnh_pkg::CFG_W-1:0]     cfg_data_i,
  rsnh_in_if.sink                        in_i,
  rsnh_out_if.source                     out_o
);
  import rsnh_pkg::*;

  localparam int IW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int QW  = (FRAC_BITS + 14 > 15) ? FRAC_BITS + 14 : 15;
  localparam int DW  = FRAC_BITS + 42;
  localparam int HSW = QW + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_HPROD = 4'd2;
  localparam logic [3:0] S_HNUM  = 4'd3;
  localparam logic [3:0] S_DIVX  = 4'd4;
  localparam logic [3:0] S_DIVY  = 4'd5;
  localparam logic [3:0] S_DWAIT = 4'd6;
  localparam logic [3:0] S_DFIN  = 4'd7;
  localparam logic [3:0] S_ULEN  = 4'd8;
  localparam logic [3:0] S_USQ   = 4'd9;
  localparam logic [3:0] S_USQW  = 4'd10;
  localparam logic [3:0] S_UFIN  = 4'd11;
  localparam logic [3:0] S_REF1  = 4'd12;
  localparam logic [3:0] S_REF2  = 4'd13;
  localparam logic [3:0] S_REF3  = 4'd14;
  localparam logic [3:0] S_REF4  = 4'd15;

  localparam logic JOB_HIT = 1'b0;
  localparam logic JOB_UV  = 1'b1;

  localparam logic signed [HSW-1:0] HMIN = HSW'(-65536);
  localparam logic signed [HSW-1:0] HMAX = HSW'(65535);
  localparam logic signed [QW:0]    UMIN = (QW+1)'(-UNIT_ONE);
  localparam logic signed [QW:0]    UMAX = (QW+1)'(UNIT_ONE);
  localparam logic signed [18:0]    RMIN = 19'(-UNIT_ONE);
  localparam logic signed [18:0]    RMAX = 19'(UNIT_ONE);

  logic [3:0] state_q;
  logic       job_q, is_q;

  // Configuration.
  logic signed [12:0] ox_q, oy_q;
  logic [7:0]         active_q;

  // Latched item.
  logic [6:0]         sidx_q;
  logic signed [12:0] ax_q, ay_q, bx_q, by_q;
  logic signed [13:0] sxv_q, syv_q, vx_q, vy_q;

  // Segment table.
  seg_entry_t seg_mem [MAX_SEGMENTS];
  seg_entry_t rd_q;
  logic [IW-1:0] rd_addr;
  logic          mem_we;

  // Scan pipeline.
  logic [IW:0]   cnt_q, nlim;
  logic          ph_q;
  logic          va_q, vb_q, vc_q, vd_q;
  logic [IW-1:0] idxa_q, idxb_q, idxc_q, idxd_q;
  logic signed [27:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  logic          okc_q, okd_q;
  logic [27:0]   unc_q, denc_q, und_q, dend_q;
  logic [55:0]   m1_q, m2_q;
  logic          found_q;
  logic [IW-1:0] best_q;
  logic [27:0]   bun_q, bden_q;
  logic          upd;

  logic signed [13:0] rxv, ryv, qxv, qyv;
  logic signed [28:0] den_s, tn_s, un_s, denm, tnn, unn;
  logic               ok_c;

  // Division and root.
  logic [40:0]    hp0_q, hp1_q;
  logic [DW-1:0]  num0_q, num1_q, dden_q;
  logic           neg0_q, neg1_q;
  logic           dcnt_q;
  logic signed [QW:0] q0_q, q1_q;
  logic           div_v, div_neg;
  logic [DW-1:0]  div_mag;
  logic           dq_v, dq_neg;
  logic [QW-1:0]  dq;
  logic signed [QW:0] dq_s;
  logic [26:0]    len2_q;
  logic           sq_start, sq_done;
  logic [SQ_RW-1:0] sq_root;
  logic [12:0]    absx, absy, absvx, absvy;

  // Results.
  logic signed [15:0] ux_q, uy_q, rx_q, ry_q;
  logic signed [16:0] hx_q, hy_q;
  logic signed [HSW-1:0] hsum0, hsum1;
  logic signed [16:0] nx, ny;
  logic signed [32:0] rp1_q, rp2_q;
  logic signed [33:0] d_q;
  logic signed [50:0] t0_q, t1_q;
  logic [50:0]        t0m, t1m;
  logic signed [18:0] c0, c1, rs0, rs1;

  assign in_i.ready = (state_q == S_IDLE);

  assign nlim = (32'(active_q) < 32'(MAX_SEGMENTS)) ? (IW+1)'(active_q)
                                                    : (IW+1)'(MAX_SEGMENTS);
  assign rd_addr = (state_q == S_SCAN) ? cnt_q[IW-1:0] : best_q;
  assign mem_we  = (state_q == S_UFIN) && !is_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seg_mem[IW'(sidx_q)] <= '{ax: ax_q, ay: ay_q, bx: bx_q, by: by_q, ux: ux_q, uy: uy_q};
    end
    rd_q <= seg_mem[rd_addr];
  end

  // Stage b: edge vectors and cross products.
  assign rxv = 14'(rd_q.bx) - 14'(rd_q.ax);
  assign ryv = 14'(rd_q.by) - 14'(rd_q.ay);
  assign qxv = 14'(ox_q) - 14'(rd_q.ax);
  assign qyv = 14'(oy_q) - 14'(rd_q.ay);

  // Stage c: denominators made positive, range tests.
  assign den_s = 29'(p1_q) - 29'(p2_q);
  assign tn_s  = 29'(p3_q) - 29'(p4_q);
  assign un_s  = 29'(p5_q) - 29'(p6_q);
  assign denm  = den_s[28] ? -den_s : den_s;
  assign tnn   = den_s[28] ? -tn_s : tn_s;
  assign unn   = den_s[28] ? -un_s : un_s;
  assign ok_c  = (den_s != '0) && !tnn[28] && (tnn <= denm) && !unn[28] && (unn <= denm);

  // Update: the nearer hit wins, and the earlier index keeps a tie.
  assign upd = vd_q && okd_q && (!found_q || (m1_q < m2_q));

  assign absx  = sxv_q[13] ? 13'(-sxv_q) : 13'(sxv_q);
  assign absy  = syv_q[13] ? 13'(-syv_q) : 13'(syv_q);
  assign absvx = vx_q[13] ? 13'(-vx_q) : 13'(vx_q);
  assign absvy = vy_q[13] ? 13'(-vy_q) : 13'(vy_q);

  assign div_v   = (state_q == S_DIVX) || (state_q == S_DIVY);
  assign div_neg = (state_q == S_DIVX) ? neg0_q : neg1_q;
  assign div_mag = (state_q == S_DIVX) ? num0_q : num1_q;
  assign dq_s    = dq_neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});

  rsnh_divider #(.DW(DW), .QW(QW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_v_i    (div_v),
    .in_neg_i  (div_neg),
    .in_mag_i  (div_mag),
    .in_den_i  (dden_q),
    .out_v_o   (dq_v),
    .out_neg_o (dq_neg),
    .out_q_o   (dq)
  );

  assign sq_start = (state_q == S_USQ);

  rsnh_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (SQ_W'({len2_q, 16'b0})),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign hsum0 = (HSW'(ox_q) <<< FRAC_BITS) + HSW'(q0_q);
  assign hsum1 = (HSW'(oy_q) <<< FRAC_BITS) + HSW'(q1_q);

  assign nx  = -17'(rd_q.uy);
  assign ny  = 17'(rd_q.ux);
  assign t0m = t0_q[50] ? 51'(-t0_q) : 51'(t0_q);
  assign t1m = t1_q[50] ? 51'(-t1_q) : 51'(t1_q);
  // Rounded 2*t/2^28, halves away from zero.
  assign c0  = t0_q[50] ? -19'((t0m + 51'(1 << 26)) >> 27) : 19'((t0m + 51'(1 << 26)) >> 27);
  assign c1  = t1_q[50] ? -19'((t1m + 51'(1 << 26)) >> 27) : 19'((t1m + 51'(1 << 26)) >> 27);
  assign rs0 = 19'(ux_q) - c0;
  assign rs1 = 19'(uy_q) - c1;

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ox_q        <= ORIGIN_RST;
      oy_q        <= ORIGIN_RST;
      active_q    <= '0;
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      vd_q        <= 1'b0;
      found_q     <= 1'b0;
      cnt_q       <= '0;
      ph_q        <= 1'b0;
      dcnt_q      <= 1'b0;
      job_q       <= JOB_HIT;
      is_q        <= 1'b0;
      out_o.valid <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ORIGIN_X: ox_q <= cfg_data_i;
          REG_ORIGIN_Y: oy_q <= cfg_data_i;
          REG_ACTIVE:   active_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (out_o.valid && out_o.ready && (state_q != S_REF4)) begin
        out_o.valid <= 1'b0;
      end

      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      va_q <= (state_q == S_SCAN) && !ph_q && (cnt_q < nlim);
      if (upd) begin
        found_q <= 1'b1;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            is_q <= (in_i.kind == KIND_QUERY);
            if (in_i.kind == KIND_QUERY) begin
              cnt_q   <= '0;
              ph_q    <= 1'b0;
              found_q <= 1'b0;
              state_q <= S_SCAN;
            end else if (32'(in_i.seg_index) < 32'(MAX_SEGMENTS)) begin
              job_q   <= JOB_UV;
              state_q <= S_ULEN;
            end
          end
        end
        S_SCAN: begin
          ph_q <= ~ph_q;
          if (!ph_q && (cnt_q < nlim)) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if ((cnt_q == nlim) && !va_q && !vb_q && !vc_q && !vd_q) begin
            state_q <= found_q ? S_HPROD : S_REF4;
          end
        end
        S_HPROD: state_q <= S_HNUM;
        S_HNUM: begin
          job_q   <= JOB_HIT;
          state_q <= S_DIVX;
        end
        S_DIVX: state_q <= S_DIVY;
        S_DIVY: begin
          dcnt_q  <= 1'b0;
          state_q <= S_DWAIT;
        end
        S_DWAIT: begin
          if (dq_v) begin
            dcnt_q <= 1'b1;
            if (dcnt_q) begin
              state_q <= S_DFIN;
            end
          end
        end
        S_DFIN: begin
          if (job_q == JOB_HIT) begin
            job_q   <= JOB_UV;
            state_q <= S_ULEN;
          end else begin
            state_q <= S_UFIN;
          end
        end
        S_ULEN: state_q <= S_USQ;
        S_USQ:  state_q <= S_USQW;
        S_USQW: begin
          if (sq_done) begin
            state_q <= (sq_root == '0) ? S_UFIN : S_DIVX;
          end
        end
        S_UFIN: state_q <= is_q ? S_REF1 : S_IDLE;
        S_REF1: state_q <= S_REF2;
        S_REF2: state_q <= S_REF3;
        S_REF3: state_q <= S_REF4;
        S_REF4: begin
          // The result moves in only when the output register is empty or its beat is taken in the same cycle.
          if (!out_o.valid || out_o.ready) begin
            out_o.valid <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_i.valid) begin
      sidx_q <= in_i.seg_index;
      ax_q   <= in_i.seg_ax;
      ay_q   <= in_i.seg_ay;
      bx_q   <= in_i.seg_bx;
      by_q   <= in_i.seg_by;
      vx_q   <= 14'(in_i.seg_bx) - 14'(in_i.seg_ax);
      vy_q   <= 14'(in_i.seg_by) - 14'(in_i.seg_ay);
      sxv_q  <= 14'(in_i.target_x) - 14'(ox_q);
      syv_q  <= 14'(in_i.target_y) - 14'(oy_q);
    end

    idxa_q <= cnt_q[IW-1:0];
    idxb_q <= idxa_q;
    p1_q   <= rxv * syv_q;
    p2_q   <= ryv * sxv_q;
    p3_q   <= qxv * syv_q;
    p4_q   <= qyv * sxv_q;
    p5_q   <= qxv * ryv;
    p6_q   <= qyv * rxv;
    idxc_q <= idxb_q;
    okc_q  <= ok_c;
    unc_q  <= 28'(unn);
    denc_q <= 28'(denm);
    idxd_q <= idxc_q;
    okd_q  <= okc_q;
    und_q  <= unc_q;
    dend_q <= denc_q;
    m1_q   <= unc_q * bden_q;
    m2_q   <= bun_q * denc_q;
    if (upd) begin
      best_q <= idxd_q;
      bun_q  <= und_q;
      bden_q <= dend_q;
    end

    if (state_q == S_HPROD) begin
      hp0_q  <= bun_q * absx;
      hp1_q  <= bun_q * absy;
      neg0_q <= sxv_q[13];
      neg1_q <= syv_q[13];
    end
    if (state_q == S_HNUM) begin
      num0_q <= (DW'(hp0_q) << FRAC_BITS) + DW'(bden_q >> 1);
      num1_q <= (DW'(hp1_q) << FRAC_BITS) + DW'(bden_q >> 1);
      dden_q <= DW'(bden_q);
    end
    if ((state_q == S_DWAIT) && dq_v) begin
      if (dcnt_q) begin
        q1_q <= dq_s;
      end else begin
        q0_q <= dq_s;
      end
    end
    if (state_q == S_DFIN) begin
      if (job_q == JOB_HIT) begin
        hx_q <= (hsum0 < HMIN) ? 17'(HMIN) : ((hsum0 > HMAX) ? 17'(HMAX) : 17'(hsum0));
        hy_q <= (hsum1 < HMIN) ? 17'(HMIN) : ((hsum1 > HMAX) ? 17'(HMAX) : 17'(hsum1));
        vx_q <= sxv_q;
        vy_q <= syv_q;
      end else begin
        ux_q <= (q0_q < UMIN) ? 16'(UMIN) : ((q0_q > UMAX) ? 16'(UMAX) : 16'(q0_q));
        uy_q <= (q1_q < UMIN) ? 16'(UMIN) : ((q1_q > UMAX) ? 16'(UMAX) : 16'(q1_q));
      end
    end
    if (state_q == S_ULEN) begin
      len2_q <= 27'(vx_q * vx_q) + 27'(vy_q * vy_q);
    end
    if ((state_q == S_USQW) && sq_done) begin
      num0_q <= (DW'(absvx) << 22) + DW'(sq_root >> 1);
      num1_q <= (DW'(absvy) << 22) + DW'(sq_root >> 1);
      neg0_q <= vx_q[13];
      neg1_q <= vy_q[13];
      dden_q <= DW'(sq_root);
      if (sq_root == '0) begin
        ux_q <= '0;
        uy_q <= '0;
      end
    end
    if (state_q == S_REF1) begin
      rp1_q <= nx * ux_q;
      rp2_q <= ny * uy_q;
    end
    if (state_q == S_REF2) begin
      d_q <= 34'(rp1_q) + 34'(rp2_q);
    end
    if (state_q == S_REF3) begin
      t0_q <= nx * d_q;
      t1_q <= ny * d_q;
    end
    if ((state_q == S_REF4) && (!out_o.valid || out_o.ready)) begin
      out_o.hit       <= found_q;
      out_o.hit_index <= found_q ? 7'(best_q) : 7'd0;
      out_o.hit_x     <= found_q ? hx_q : 17'sd0;
      out_o.hit_y     <= found_q ? hy_q : 17'sd0;
      out_o.reflect_x <= !found_q ? 16'sd0 :
                         (rs0 < RMIN) ? 16'(RMIN) : ((rs0 > RMAX) ? 16'(RMAX) : 16'(rs0));
      out_o.reflect_y <= !found_q ? 16'sd0 :
                         (rs1 < RMIN) ? 16'(RMIN) : ((rs1 > RMAX) ? 16'(RMAX) : 16'(rs1));
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dq_v |-> (state_q == S_DWAIT))
    else $error("divider result outside the collect state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == S_USQW))
    else $error("root finished outside its wait state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> ((IW+1)'(best_q) < cnt_q))
    else $error("best index beyond scanned entries");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.hit) |-> ((out_o.reflect_x == '0) && (out_o.reflect_y == '0)))
    else $error("miss beat with nonzero reflection");

endmodule

### tb/tb_ray_segment_nearest_hit_reflect.sv
`timescale 1ns / 100ps

module tb_ray_segment_nearest_hit_reflect;
  import rsnh_pkg::*;

  localparam int TABLE_SIZE  = MAX_SEG_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic                    kind;
    logic [IDX_W-1:0]        seg_index;
    logic signed [CRD_W-1:0] ax, ay, bx, by, tx, ty;
  } item_t;

  typedef struct {
    logic                     hit;
    logic [IDX_W-1:0]         idx;
    logic signed [HIT_W-1:0]  hx, hy;
    logic signed [UNIT_W-1:0] rx, ry;
  } hit_res_t;

  class hit_scoreboard;
    longint org_x = 512, org_y = 512, n_active = 0;
    longint tab_ax[TABLE_SIZE], tab_ay[TABLE_SIZE], tab_bx[TABLE_SIZE], tab_by[TABLE_SIZE];
    longint tab_ux[TABLE_SIZE], tab_uy[TABLE_SIZE];
    hit_res_t pending[$];
    int unsigned mismatches = 0, checked = 0, hits = 0;

    function longint round_div(longint num, longint den);
      longint mag;
      mag = num < 0 ? -num : num;
      mag = (mag + den / 2) / den;
      return num < 0 ? -mag : mag;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    function void unit_dir(input longint vx, input longint vy,
                           output longint ux, output longint uy);
      longint len;
      len = int_sqrt(longint'(vx * vx + vy * vy) << 16);
      if (len == 0) begin
        ux = 0;
        uy = 0;
      end else begin
        ux = clamp(round_div(vx * 4194304, len), -UNIT_ONE, UNIT_ONE);
        uy = clamp(round_div(vy * 4194304, len), -UNIT_ONE, UNIT_ONE);
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_ORIGIN_X) org_x = longint'(signed'(data));
      else if (idx == REG_ORIGIN_Y) org_y = longint'(signed'(data));
      else if (idx == REG_ACTIVE) n_active = longint'(data[7:0]);
    endfunction

    // Loads only update the table; a query queues exactly one result.
    function void note_input(item_t it);
      longint sx, sy, n, rxv, ryv, qx, qy, den, tn, un;
      longint best_un, best_den, hx, hy, ix, iy, nx, ny, d, rx, ry, ux, uy;
      int best;
      bit found;
      hit_res_t r;
      if (it.kind == KIND_LOAD) begin
        tab_ax[it.seg_index] = it.ax;
        tab_ay[it.seg_index] = it.ay;
        tab_bx[it.seg_index] = it.bx;
        tab_by[it.seg_index] = it.by;
        unit_dir(longint'(it.bx) - it.ax, longint'(it.by) - it.ay, ux, uy);
        tab_ux[it.seg_index] = ux;
        tab_uy[it.seg_index] = uy;
        return;
      end
      sx = longint'(it.tx) - org_x;
      sy = longint'(it.ty) - org_y;
      n = n_active < TABLE_SIZE ? n_active : TABLE_SIZE;
      found = 0;
      best = 0;
      best_un = 0;
      best_den = 1;
      for (int i = 0; i < n; i++) begin
        rxv = tab_bx[i] - tab_ax[i];
        ryv = tab_by[i] - tab_ay[i];
        qx = org_x - tab_ax[i];
        qy = org_y - tab_ay[i];
        den = rxv * sy - ryv * sx;
        tn = qx * sy - qy * sx;
        un = qx * ryv - qy * rxv;
        if (den == 0) continue;
        if (den < 0) begin
          den = -den;
          tn = -tn;
          un = -un;
        end
        if (tn < 0 || tn > den || un < 0 || un > den) continue;
        if (!found || un * best_den < best_un * den) begin
          found = 1;
          best = i;
          best_un = un;
          best_den = den;
        end
      end
      r = '{hit: 1'b0, idx: '0, hx: '0, hy: '0, rx: '0, ry: '0};
      if (found) begin
        hx = clamp(org_x * 16 + round_div(best_un * sx * 16, best_den), -65536, 65535);
        hy = clamp(org_y * 16 + round_div(best_un * sy * 16, best_den), -65536, 65535);
        unit_dir(sx, sy, ix, iy);
        nx = -tab_uy[best];
        ny = tab_ux[best];
        d = nx * ix + ny * iy;
        rx = clamp(ix - round_div(2 * nx * d, 64'sd1 << 28), -UNIT_ONE, UNIT_ONE);
        ry = clamp(iy - round_div(2 * ny * d, 64'sd1 << 28), -UNIT_ONE, UNIT_ONE);
        r = '{hit: 1'b1, idx: best[IDX_W-1:0], hx: hx[HIT_W-1:0], hy: hy[HIT_W-1:0],
              rx: rx[UNIT_W-1:0], ry: ry[UNIT_W-1:0]};
      end
      pending = {pending, r};
    endfunction

    function void check(hit_res_t got);
      hit_res_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result beat with nothing expected");
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.hit) hits++;
      if (got.hit !== e.hit || got.idx !== e.idx || got.hx !== e.hx || got.hy !== e.hy ||
          got.rx !== e.rx || got.ry !== e.ry) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: result %0d exp hit=%0d idx=%0d p=(%0d,%0d) r=(%0d,%0d)",
                    " got hit=%0d idx=%0d p=(%0d,%0d) r=(%0d,%0d)"},
                   checked, e.hit, e.idx, e.hx, e.hy, e.rx, e.ry,
                   got.hit, got.idx, got.hx, got.hy, got.rx, got.ry);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  rsnh_in_if  in_if ();
  rsnh_out_if out_if ();

  ray_segment_nearest_hit_reflect dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  always #1 clk_i = ~clk_i;

  hit_scoreboard sb = new();
  bit no_idle = 0;
  int holds_asked = 0, holds_done = 0, hold_left = 0;
  int unsigned n_loads = 0, n_queries = 0, n_cfg = 0, idle_cycles = 0;
  bit loaded[TABLE_SIZE];

  // Receiver: random back-pressure plus the occasional long hold-off.
  always @(negedge clk_i) begin
    if (hold_left == 0 && holds_done < holds_asked) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= no_idle || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check('{hit: out_if.hit, idx: out_if.hit_index, hx: out_if.hit_x, hy: out_if.hit_y,
                 rx: out_if.reflect_x, ry: out_if.reflect_y});
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ray_segment_nearest_hit_reflect verification failed");
        $finish;
      end
    end
  end

  task automatic send_item(item_t it);
    int gap;
    if (!no_idle && $urandom_range(99) < 18) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.kind      <= it.kind;
    in_if.seg_index <= it.seg_index;
    in_if.seg_ax    <= it.ax;
    in_if.seg_ay    <= it.ay;
    in_if.seg_bx    <= it.bx;
    in_if.seg_by    <= it.by;
    in_if.target_x  <= it.tx;
    in_if.target_y  <= it.ty;
    in_if.valid     <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(it);
    if (it.kind == KIND_LOAD) begin
      n_loads++;
      loaded[it.seg_index] = 1'b1;
    end else begin
      n_queries++;
    end
    @(negedge clk_i);
  endtask

  // Stop offering beats, wait for every result, then let a trailing load finish.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    n_cfg++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [CRD_W-1:0] crd(longint v);
    longint c;
    c = v < -4096 ? -4096 : (v > 4095 ? 4095 : v);
    return c[CRD_W-1:0];
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.kind      = 1'($urandom_range(1));
    it.seg_index = IDX_W'($urandom_range(127));
    it.ax = CRD_W'($urandom_range(8191));
    it.ay = CRD_W'($urandom_range(8191));
    it.bx = CRD_W'($urandom_range(8191));
    it.by = CRD_W'($urandom_range(8191));
    it.tx = CRD_W'($urandom_range(8191));
    it.ty = CRD_W'($urandom_range(8191));
    return it;
  endfunction

  function automatic item_t make_load(int idx, longint ax, longint ay, longint bx, longint by);
    item_t it;
    it = rand_item();
    it.kind = KIND_LOAD;
    it.seg_index = idx[IDX_W-1:0];
    it.ax = crd(ax);
    it.ay = crd(ay);
    it.bx = crd(bx);
    it.by = crd(by);
    return it;
  endfunction

  function automatic item_t make_query(longint tx, longint ty);
    item_t it;
    it = rand_item();
    it.kind = KIND_QUERY;
    it.tx = crd(tx);
    it.ty = crd(ty);
    return it;
  endfunction

  function automatic int loaded_prefix();
    int p;
    p = 0;
    while (p < TABLE_SIZE && loaded[p]) p++;
    return p;
  endfunction

  function automatic item_t random_load();
    int idx, p, sel;
    longint cx, cy;
    item_t it;
    p = loaded_prefix();
    idx = (p < TABLE_SIZE && $urandom_range(99) < 60) ? p : $urandom_range(TABLE_SIZE - 1);
    sel = $urandom_range(99);
    cx = $signed($urandom_range(8191)) - 4096;
    cy = $signed($urandom_range(8191)) - 4096;
    if (sel < 40) begin
      it = rand_item();
      it.kind = KIND_LOAD;
      it.seg_index = idx[IDX_W-1:0];
    end else if (sel < 85) begin
      it = make_load(idx, sb.org_x + ($signed($urandom_range(1600)) - 800),
                     sb.org_y + ($signed($urandom_range(1600)) - 800),
                     sb.org_x + ($signed($urandom_range(1600)) - 800),
                     sb.org_y + ($signed($urandom_range(1600)) - 800));
    end else if (sel < 92) begin
      it = make_load(idx, cx, cy, cx, cy);
    end else begin
      it = make_load(idx, cx, cy, cx + $urandom_range(300), cy);
    end
    return it;
  endfunction

  // Most queries aim through a stored segment so the nearest-hit logic is exercised.
  function automatic item_t random_query();
    int sel, n, i;
    longint mx, my;
    sel = $urandom_range(99);
    n = int'(sb.n_active < TABLE_SIZE ? sb.n_active : TABLE_SIZE);
    if (n > 0 && sel < 55) begin
      i = $urandom_range(n - 1);
      mx = (sb.tab_ax[i] + sb.tab_bx[i]) / 2;
      my = (sb.tab_ay[i] + sb.tab_by[i]) / 2;
      return make_query(2 * mx - sb.org_x + $signed($urandom_range(20)) - 10,
                        2 * my - sb.org_y + $signed($urandom_range(20)) - 10);
    end else if (n > 0 && sel < 62) begin
      i = $urandom_range(n - 1);
      return make_query(sb.tab_bx[i], sb.tab_by[i]);
    end else if (sel < 68) begin
      return make_query(sb.org_x, sb.org_y);
    end
    return make_query($signed($urandom_range(8191)) - 4096, $signed($urandom_range(8191)) - 4096);
  endfunction

  initial begin
    int p, act;
    longint ox, oy;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_ORIGIN_X;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_LOAD;
    in_if.seg_index = '0;
    in_if.seg_ax = '0;
    in_if.seg_ay = '0;
    in_if.seg_bx = '0;
    in_if.seg_by = '0;
    in_if.target_x = '0;
    in_if.target_y = '0;
    out_if.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (5) @(negedge clk_i);

    // Directed: empty table, tie, degenerate, collinear, endpoint touch, field extremes.
    send_item(make_query(1000, 500));
    send_item(make_load(0, 600, 0, 600, 1000));
    send_item(make_load(1, 600, 0, 600, 1000));
    send_item(make_load(2, 700, 700, 700, 700));
    send_item(make_load(3, -4096, -4096, 4095, 4095));
    send_item(make_load(4, 4095, -4096, -4096, 4095));
    send_item(make_load(5, 1000, 400, 1000, 600));
    drain();
    write_reg(REG_ACTIVE, 13'd6);
    send_item(make_query(1000, 500));
    send_item(make_query(512, 512));
    send_item(make_query(700, 700));
    send_item(make_query(4095, 4095));
    send_item(make_query(-4096, -4096));
    send_item(make_query(4095, -4096));
    send_item(make_query(-4096, 4095));
    send_item(make_query(600, 1000));
    drain();
    write_reg(REG_ORIGIN_X, 13'h1000);
    write_reg(REG_ORIGIN_Y, 13'h0fff);
    send_item(make_query(4095, -4096));
    send_item(make_query(4095, 4095));
    send_item(make_query(-4096, 4095));
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin
          ox = $signed($urandom_range(8191)) - 4096;
          oy = $signed($urandom_range(8191)) - 4096;
        end
        1: begin
          ox = -4096;
          oy = 4095;
        end
        2: begin
          ox = 4095;
          oy = -4096;
        end
        default: begin
          ox = $signed($urandom_range(1000)) - 500;
          oy = $signed($urandom_range(1000)) - 500;
        end
      endcase
      p = loaded_prefix();
      if (ph == 0) act = 0;
      else if (p == TABLE_SIZE && ph % 3 == 0) act = 255;
      else if (p == TABLE_SIZE && ph % 3 == 1) act = TABLE_SIZE;
      else act = $urandom_range(p);
      write_reg(REG_ORIGIN_X, crd(ox));
      write_reg(REG_ORIGIN_Y, crd(oy));
      write_reg(REG_ACTIVE, act[CFG_W-1:0]);
      no_idle = (ph == 3);
      if (ph == 5) holds_asked++;
      for (int k = 0; k < 136; k++) begin
        if ($urandom_range(99) < 35) send_item(random_load());
        else send_item(random_query());
      end
      no_idle = 0;
      drain();
    end

    repeat (400) @(negedge clk_i);
    $display("Sent %0d loads and %0d queries over %0d register writes.",
             n_loads, n_queries, n_cfg);
    $display("Checked %0d results, %0d of them hits; %0d mismatches, %0d still pending.",
             sb.checked, sb.hits, sb.mismatches, sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ray_segment_nearest_hit_reflect verification clean");
    end else begin
      $display("ray_segment_nearest_hit_reflect verification failed");
    end
    $finish;
  end

endmodule
